### rtl/i2cs_pkg.sv
package i2cs_pkg;

    localparam int RX_DEPTH = 32;
    localparam int TX_DEPTH = 32;
    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
    localparam int LEVEL_W  = 6;
    localparam int ADDR_W   = 7;

    localparam logic [2:0] ACT_BUS_EVENT  = 3'd0;
    localparam logic [2:0] ACT_SHIFT_DONE = 3'd1;
    localparam logic [2:0] ACT_PUSH_TX    = 3'd2;
    localparam logic [2:0] ACT_POP_RX     = 3'd3;
    localparam logic [2:0] ACT_FLUSH_TX   = 3'd4;

    localparam logic [7:0] GENERAL_CALL = 8'h00;
    localparam logic [3:0] BITS_DATA    = 4'd8;
    localparam logic [3:0] BITS_ACK     = 4'd1;

    typedef enum logic [5:0] {
        PH_CHECK_ADDR  = 6'b000001,
        PH_SEND_DATA   = 6'b000010,
        PH_REQ_REPLY   = 6'b000100,
        PH_CHECK_REPLY = 6'b001000,
        PH_REQ_DATA    = 6'b010000,
        PH_GET_DATA    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [2:0] action;
        logic       sda_high;
        logic [7:0] byte_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         shift_load;
        logic               sda_drive;
        logic [3:0]         bits_to_shift;
        logic               listening;
        logic               addressed_read;
        logic [7:0]         rx_byte;
        logic               rx_valid;
        logic               fifo_error;
        logic [LEVEL_W-1:0] tx_level;
        logic [LEVEL_W-1:0] rx_level;
    } out_item_t;

    typedef struct packed {
        logic               load_sel;
        logic               sda_drive;
        logic [3:0]         bits_to_shift;
        logic               listening;
        logic               addressed_read;
        logic               rx_valid;
        logic               fifo_error;
        logic [LEVEL_W-1:0] tx_level;
        logic [LEVEL_W-1:0] rx_level;
    } stage_t;

endpackage

### rtl/i2c_slave_byte_fsm_with_fifos.sv
// Byte-level I2C slave sequencer with a 32-byte receive FIFO and a 32-byte transmit FIFO.
// Each input beat (start/stop, shift done, push tx, pop rx, flush tx) gives exactly one
// result beat telling the shift engine what to load, whether to drive SDA and how many
// bits come next, plus FIFO levels and popped data. Beats are taken one per clock while
// s_ready is high; a beat goes into the first stage with the registered FIFO read, then
// into the output register, and back pressure on the result side stalls the input side
// only once both internal stages are full. The user must write own_address through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce this.
module i2c_slave_byte_fsm_with_fifos
    import i2cs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [ADDR_W-1:0]   cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_item
);

    logic [ADDR_W-1:0]   own_address_reg;
    phase_t              phase_reg, phase_next;
    logic                listen_reg, listen_next;

    logic [7:0]          rx_mem [RX_DEPTH];
    logic [7:0]          tx_mem [TX_DEPTH];
    logic [RX_PTR_W-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_PTR_W-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [RX_CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [TX_CNT_W-1:0] tx_count_reg, tx_count_next;
    logic [7:0]          rx_rd_reg, tx_rd_reg;

    logic                rx_wr, tx_wr;
    logic                accept, advance;
    logic                a_valid_reg;
    stage_t              a_reg, a_next;
    logic                m_valid_reg;
    out_item_t           m_item_reg;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !a_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        phase_next    = phase_reg;
        listen_next   = listen_reg;
        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        rx_count_next = rx_count_reg;
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        tx_count_next = tx_count_reg;
        rx_wr         = 1'b0;
        tx_wr         = 1'b0;
        a_next        = '0;
        a_next.bits_to_shift = BITS_DATA;

        unique case (s_item.action)
            ACT_BUS_EVENT: begin
                phase_next  = PH_CHECK_ADDR;
                listen_next = !s_item.sda_high;
            end
            ACT_SHIFT_DONE: begin
                if (listen_reg) begin
                    unique case (phase_reg) inside
                        PH_CHECK_ADDR: begin
                            if (s_item.byte_in == GENERAL_CALL
                                    || s_item.byte_in[7:1] == own_address_reg) begin
                                if (s_item.byte_in[0]) begin
                                    a_next.addressed_read = 1'b1;
                                    phase_next = PH_SEND_DATA;
                                end else begin
                                    phase_next = PH_REQ_DATA;
                                end
                                a_next.sda_drive     = 1'b1;
                                a_next.bits_to_shift = BITS_ACK;
                            end else begin
                                listen_next = 1'b0;
                            end
                        end
                        PH_SEND_DATA, PH_CHECK_REPLY: begin
                            if (phase_reg == PH_CHECK_REPLY && s_item.byte_in != 8'd0) begin
                                // master nack ends the read
                                listen_next = 1'b0;
                            end else if (tx_count_reg != '0) begin
                                a_next.load_sel  = 1'b1;
                                a_next.sda_drive = 1'b1;
                                tx_tail_next = (tx_tail_reg == TX_PTR_W'(TX_DEPTH - 1))
                                    ? '0 : tx_tail_reg + 1'b1;
                                tx_count_next = tx_count_reg - 1'b1;
                                phase_next    = PH_REQ_REPLY;
                            end else begin
                                listen_next = 1'b0;
                            end
                        end
                        PH_REQ_REPLY: begin
                            phase_next           = PH_CHECK_REPLY;
                            a_next.bits_to_shift = BITS_ACK;
                        end
                        PH_REQ_DATA: begin
                            phase_next = PH_GET_DATA;
                        end
                        PH_GET_DATA: begin
                            // full fifo drops the byte but still acks
                            if (rx_count_reg < RX_CNT_W'(RX_DEPTH)) begin
                                rx_wr        = 1'b1;
                                rx_head_next = (rx_head_reg == RX_PTR_W'(RX_DEPTH - 1))
                                    ? '0 : rx_head_reg + 1'b1;
                                rx_count_next = rx_count_reg + 1'b1;
                            end
                            phase_next           = PH_REQ_DATA;
                            a_next.sda_drive     = 1'b1;
                            a_next.bits_to_shift = BITS_ACK;
                        end
                        default: begin
                            phase_next  = PH_CHECK_ADDR;
                            listen_next = 1'b0;
                        end
                    endcase
                end
            end
            ACT_PUSH_TX: begin
                if (tx_count_reg < TX_CNT_W'(TX_DEPTH)) begin
                    tx_wr        = 1'b1;
                    tx_head_next = (tx_head_reg == TX_PTR_W'(TX_DEPTH - 1))
                        ? '0 : tx_head_reg + 1'b1;
                    tx_count_next = tx_count_reg + 1'b1;
                end else begin
                    a_next.fifo_error = 1'b1;
                end
            end
            ACT_POP_RX: begin
                if (rx_count_reg != '0) begin
                    a_next.rx_valid = 1'b1;
                    rx_tail_next = (rx_tail_reg == RX_PTR_W'(RX_DEPTH - 1))
                        ? '0 : rx_tail_reg + 1'b1;
                    rx_count_next = rx_count_reg - 1'b1;
                end else begin
                    a_next.fifo_error = 1'b1;
                end
            end
            ACT_FLUSH_TX: begin
                tx_count_next = '0;
                tx_head_next  = '0;
                tx_tail_next  = '0;
            end
            default: begin
            end
        endcase

        a_next.listening = listen_next;
        a_next.tx_level  = LEVEL_W'(tx_count_next);
        a_next.rx_level  = LEVEL_W'(rx_count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= '0;
        end else if (cfg_wr_en) begin
            own_address_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_CHECK_ADDR;
            listen_reg   <= 1'b0;
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            rx_count_reg <= '0;
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            tx_count_reg <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            listen_reg   <= listen_next;
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            rx_count_reg <= rx_count_next;
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            tx_count_reg <= tx_count_next;
        end
    end

    // fifo memories, read at the tail on every accepted beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (rx_wr) begin
                rx_mem[rx_head_reg] <= s_item.byte_in;
            end
            if (tx_wr) begin
                tx_mem[tx_head_reg] <= s_item.byte_in;
            end
            rx_rd_reg <= rx_mem[rx_tail_reg];
            tx_rd_reg <= tx_mem[tx_tail_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_reg <= a_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && a_valid_reg) begin
            m_item_reg.shift_load     <= a_reg.load_sel ? tx_rd_reg : 8'd0;
            m_item_reg.sda_drive      <= a_reg.sda_drive;
            m_item_reg.bits_to_shift  <= a_reg.bits_to_shift;
            m_item_reg.listening      <= a_reg.listening;
            m_item_reg.addressed_read <= a_reg.addressed_read;
            m_item_reg.rx_byte        <= a_reg.rx_valid ? rx_rd_reg : 8'd0;
            m_item_reg.rx_valid       <= a_reg.rx_valid;
            m_item_reg.fifo_error     <= a_reg.fifo_error;
            m_item_reg.tx_level       <= a_reg.tx_level;
            m_item_reg.rx_level       <= a_reg.rx_level;
        end
    end

endmodule
